// File: rtl/core/style_flag_visual_table_assert.svh
// ----------------------------------------------------------------------------
// style_flag_visual_table_assert
// assertion macros shared by the rtl of the style/flag table
// ----------------------------------------------------------------------------
`ifndef STYLE_FLAG_VISUAL_TABLE_ASSERT_SVH
`define STYLE_FLAG_VISUAL_TABLE_ASSERT_SVH

// same-cycle implication
`define SFVT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfvt assertion failed");

// next-cycle implication
`define SFVT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfvt assertion failed");

`endif

// File: rtl/core/sfvt_pkg.sv
// ----------------------------------------------------------------------------
// sfvt_pkg
// types and constants of the style/flag table
// ----------------------------------------------------------------------------
package sfvt_pkg;

   localparam int STYLE_W     = 6;
   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 72;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_FIND   = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_RD       = 7'b0000010,
      ST_EVAL     = 7'b0000100,
      ST_POST     = 7'b0001000,
      ST_SHIFT_RD = 7'b0010000,
      ST_SHIFT_WR = 7'b0100000,
      ST_FINISH   = 7'b1000000
   } state_type;

endpackage

// File: rtl/core/style_flag_visual_table.sv
// Style/flag table: entries sorted by style live in one single-port-read memory. A
// beat with a style below NUM_STYLES walks the memory from entry 0 up to the end of
// the addressed style's group (registered read, then compare); an insert stops early
// at an entry with equal flags, and a new entry then moves every later entry up one
// place. A beat with a larger style goes straight to the response. One item is worked
// at a time; the next beat is taken while a result waits in the output register.
// ----------------------------------------------------------------------------
// style_flag_visual_table
// keyed insert/replace and subset-match find over a sorted entry memory
// ----------------------------------------------------------------------------
`include "style_flag_visual_table_assert.svh"

module style_flag_visual_table #(
   parameter int CAPACITY     = 64,
   parameter int NUM_STYLES   = 64,
   parameter int FLAG_BITS    = 32,
   parameter int PAYLOAD_BITS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // style_id[5:0], flag_word[37:6], payload[101:38], zero fill
   input  logic [sfvt_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // op
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // result_payload[63:0], style_present, subset_matched, inserted_new,
   // table_full, zero fill
   output logic [sfvt_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SW    = sfvt_pkg::STYLE_W;
   localparam int MEM_W = PAYLOAD_BITS + FLAG_BITS + SW;

   logic [MEM_W-1:0] mem [CAPACITY];
   logic [MEM_W-1:0] mem_rd_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_wa, mem_ra;
   logic [MEM_W-1:0] mem_wd;

   sfvt_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  sh_ff, sh_in;
   logic              op_ff, op_in;
   logic [SW-1:0]     sid_ff, sid_in;
   logic [FLAG_BITS-1:0]    fl_ff, fl_in;
   logic [PAYLOAD_BITS-1:0] pl_ff, pl_in;
   logic [PAYLOAD_BITS-1:0] res_ff, res_in;
   logic present_ff, present_in, matched_ff, matched_in;
   logic added_ff, added_in, full_ff, full_in, found_ff, found_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [sfvt_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [63:0]             req_fw64;
   logic [SW-1:0]           r_style;
   logic [FLAG_BITS-1:0]    r_flags;
   logic [PAYLOAD_BITS-1:0] r_pl;
   logic [SW-1:0]           req_sid;

   assign req_sid  = req_tdata[5:0];
   assign req_fw64 = {32'b0, req_tdata[37:6]};
   assign r_style  = mem_rd_ff[SW-1:0];
   assign r_flags  = mem_rd_ff[SW +: FLAG_BITS];
   assign r_pl     = mem_rd_ff[SW + FLAG_BITS +: PAYLOAD_BITS];

   assign req_tready = (state_ff == sfvt_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= mem[mem_ra];
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      sh_in       = sh_ff;
      op_in       = op_ff;
      sid_in      = sid_ff;
      fl_in       = fl_ff;
      pl_in       = pl_ff;
      res_in      = res_ff;
      present_in  = present_ff;
      matched_in  = matched_ff;
      added_in    = added_ff;
      full_in     = full_ff;
      found_in    = found_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we      = 1'b0;
      mem_wa      = idx_ff[IDX_W-1:0];
      mem_wd      = {pl_ff, fl_ff, sid_ff};
      mem_ra      = idx_ff[IDX_W-1:0];

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         sfvt_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               op_in      = req_tuser;
               sid_in     = req_sid;
               fl_in      = req_fw64[FLAG_BITS-1:0];
               pl_in      = req_tdata[38 +: PAYLOAD_BITS];
               res_in     = '0;
               present_in = 1'b0;
               matched_in = 1'b0;
               added_in   = 1'b0;
               full_in    = 1'b0;
               found_in   = 1'b0;
               idx_in     = '0;
               if (32'(req_sid) >= NUM_STYLES) begin
                  state_in = sfvt_pkg::ST_FINISH;
               end else begin
                  state_in = sfvt_pkg::ST_RD;
               end
            end
         end
         sfvt_pkg::ST_RD: begin
            if (idx_ff == count_ff) begin
               state_in = sfvt_pkg::ST_POST;
            end else begin
               state_in = sfvt_pkg::ST_EVAL;
            end
         end
         sfvt_pkg::ST_EVAL: begin
            if (r_style < sid_ff) begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = sfvt_pkg::ST_RD;
            end else if (r_style == sid_ff) begin
               present_in = 1'b1;
               if (op_ff == sfvt_pkg::OP_FIND) begin
                  if (!present_ff) begin
                     res_in = r_pl;
                  end
                  if ((r_flags & fl_ff) == r_flags) begin
                     res_in     = r_pl;
                     matched_in = 1'b1;
                  end
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = sfvt_pkg::ST_RD;
               end else if (r_flags == fl_ff) begin
                  found_in = 1'b1;
                  state_in = sfvt_pkg::ST_POST;
               end else begin
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = sfvt_pkg::ST_RD;
               end
            end else begin
               state_in = sfvt_pkg::ST_POST;
            end
         end
         sfvt_pkg::ST_POST: begin
            if (op_ff == sfvt_pkg::OP_FIND) begin
               state_in = sfvt_pkg::ST_FINISH;
            end else if (found_ff) begin
               mem_we   = 1'b1;
               state_in = sfvt_pkg::ST_FINISH;
            end else if (count_ff == CNT_W'(CAPACITY)) begin
               full_in  = 1'b1;
               state_in = sfvt_pkg::ST_FINISH;
            end else begin
               sh_in    = count_ff;
               state_in = sfvt_pkg::ST_SHIFT_RD;
            end
         end
         sfvt_pkg::ST_SHIFT_RD: begin
            mem_ra = IDX_W'(sh_ff - CNT_W'(1));
            if (sh_ff == idx_ff) begin
               mem_we   = 1'b1;
               count_in = count_ff + CNT_W'(1);
               added_in = 1'b1;
               state_in = sfvt_pkg::ST_FINISH;
            end else begin
               state_in = sfvt_pkg::ST_SHIFT_WR;
            end
         end
         sfvt_pkg::ST_SHIFT_WR: begin
            mem_we   = 1'b1;
            mem_wa   = sh_ff[IDX_W-1:0];
            mem_wd   = mem_rd_ff;
            sh_in    = sh_ff - CNT_W'(1);
            state_in = sfvt_pkg::ST_SHIFT_RD;
         end
         sfvt_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0, full_ff, added_ff, matched_ff, present_ff,
                               64'(res_ff)};
               state_in     = sfvt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sfvt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sfvt_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      sh_ff       <= sh_in;
      op_ff       <= op_in;
      sid_ff      <= sid_in;
      fl_ff       <= fl_in;
      pl_ff       <= pl_in;
      res_ff      <= res_in;
      present_ff  <= present_in;
      matched_ff  <= matched_in;
      added_ff    <= added_in;
      full_ff     <= full_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

   `SFVT_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `SFVT_ASSERT_IMP(a_added_xor_full, clock, reset, rsp_valid_ff,
                    !(rsp_data_ff[66] && rsp_data_ff[67]))
   `SFVT_ASSERT_NXT(a_count_step, clock, reset, state_ff != sfvt_pkg::ST_SHIFT_RD,
                    count_ff == $past(count_ff))

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives insert and find beats into the style/flag table and compares every
// response against a behavioral copy of the sorted table kept in a scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CAP         = 64;
   localparam int WATCH_LIMIT = 200000;
   localparam int N_RANDOM    = 420;

   typedef struct packed {
      logic        full;
      logic        added;
      logic        matched;
      logic        present;
      logic [63:0] payload;
   } table_result_type;

   class table_scoreboard_type;
      logic [5:0]    ent_style [CAP];
      logic [31:0]   ent_flags [CAP];
      logic [63:0]   ent_pay   [CAP];
      int            grp_start [64];
      int            count;
      table_result_type pending [$];
      int            errors;

      function void clear();
         count = 0;
         errors = 0;
         foreach (grp_start[i]) grp_start[i] = 0;
      endfunction

      function void note_request(logic op, logic [5:0] sid, logic [31:0] fl,
                                 logic [63:0] pl);
         table_result_type r;
         int lo, hi;
         bit hit;
         r = '0;
         lo = grp_start[sid];
         hi = lo;
         while (hi < count && ent_style[hi] == sid) hi++;
         r.present = hi > lo;
         if (op == sfvt_pkg::OP_FIND) begin
            if (r.present) begin
               r.payload = ent_pay[lo];
               for (int i = lo; i < hi; i++)
                  if ((ent_flags[i] & fl) == ent_flags[i]) begin
                     r.payload = ent_pay[i];
                     r.matched = 1'b1;
                  end
            end
         end else begin
            hit = 0;
            for (int i = lo; i < hi && !hit; i++)
               if (ent_flags[i] == fl) begin
                  ent_pay[i] = pl;
                  hit = 1;
               end
            if (!hit) begin
               if (count >= CAP) r.full = 1'b1;
               else begin
                  for (int i = count; i > hi; i--) begin
                     ent_style[i] = ent_style[i-1];
                     ent_flags[i] = ent_flags[i-1];
                     ent_pay[i]   = ent_pay[i-1];
                  end
                  ent_style[hi] = sid;
                  ent_flags[hi] = fl;
                  ent_pay[hi]   = pl;
                  for (int s = sid + 1; s < 64; s++) grp_start[s]++;
                  count++;
                  r.added = 1'b1;
               end
            end
         end
         pending.push_back(r);
      endfunction

      function void check_response(logic [sfvt_pkg::RSP_TDATA_W-1:0] data);
         table_result_type got, want;
         got = data[67:0];
         if (pending.size() == 0) begin
            $display("%0t unexpected beat actual %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got !== want || data[sfvt_pkg::RSP_TDATA_W-1:68] !== '0) begin
            $display("%0t mismatch expected %h actual %h", $time, want, data);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tuser = 0, rsp_tready = 0;
   logic [sfvt_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic req_tready, rsp_tvalid;
   logic [sfvt_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   table_scoreboard_type board;
   int  idle_cycles;
   bit  no_gaps = 0, hold_rsp = 0, sent_all = 0;

   style_flag_visual_table dut (.*);

   initial forever #10 clock = ~clock;

   task automatic send_beat(logic op, logic [5:0] sid, logic [31:0] fl,
                            logic [63:0] pl);
      while (!no_gaps && $urandom_range(99) < 7) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b0, pl, fl, sid};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(op, sid, fl, pl);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_flags();
      case ($urandom_range(3))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h1 << $urandom_range(31);
         default: return $urandom & $urandom;
      endcase
   endfunction

   // response side
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
      rsp_tready <= !hold_rsp && (no_gaps || $urandom_range(99) >= 7);
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCH_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      logic [5:0] sid;
      board = new();
      board.clear();
      idle_cycles = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty finds, extremes, replace, subset, fill to full
      send_beat(sfvt_pkg::OP_FIND, 6'd0, 32'h0, 64'h0);
      send_beat(sfvt_pkg::OP_INSERT, 6'd63, 32'hFFFF_FFFF, '1);
      send_beat(sfvt_pkg::OP_INSERT, 6'd0, 32'h0, 64'h1);
      send_beat(sfvt_pkg::OP_INSERT, 6'd0, 32'h0, 64'hA5A5_5A5A_0F0F_F0F0);
      send_beat(sfvt_pkg::OP_INSERT, 6'd0, 32'h3, 64'h2);
      send_beat(sfvt_pkg::OP_INSERT, 6'd0, 32'h8, 64'h3);
      send_beat(sfvt_pkg::OP_FIND, 6'd0, 32'h3, 64'h0);
      send_beat(sfvt_pkg::OP_FIND, 6'd0, 32'h4, '1);
      send_beat(sfvt_pkg::OP_INSERT, 6'd5, 32'h10, 64'h5);
      send_beat(sfvt_pkg::OP_FIND, 6'd5, 32'h0, 64'h0);
      send_beat(sfvt_pkg::OP_FIND, 6'd63, 32'hFFFF_FFFF, 64'h0);
      send_beat(sfvt_pkg::OP_FIND, 6'd62, 32'hFFFF_FFFF, 64'h0);
      for (int i = 0; i < 60; i++)
         send_beat(sfvt_pkg::OP_INSERT, 6'($urandom_range(63)), $urandom | 32'h1,
                   {$urandom, $urandom});
      send_beat(sfvt_pkg::OP_INSERT, 6'd10, 32'h0, 64'h77);
      send_beat(sfvt_pkg::OP_INSERT, 6'd0, 32'h8, 64'h99);
      send_beat(sfvt_pkg::OP_FIND, 6'd0, 32'hF, 64'h0);

      // long receiver hold-off while beats keep coming
      fork
         begin
            hold_rsp = 1'b1;
            repeat (3000) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 6; i++)
            send_beat(sfvt_pkg::OP_FIND, 6'($urandom_range(63)), $urandom, 64'h0);
      join
      wait_drained();

      // random phases: clears are impossible, so vary the style spread and the gaps
      for (int n = 0; n < N_RANDOM; n++) begin
         no_gaps = (n >= 150 && n < 250);
         sid = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(7));
         if (n == 300) wait_drained();
         if ($urandom_range(1))
            send_beat(sfvt_pkg::OP_FIND, sid, rand_flags(), {$urandom, $urandom});
         else
            send_beat(sfvt_pkg::OP_INSERT, sid, rand_flags(), {$urandom, $urandom});
      end
      no_gaps = 0;
      sent_all = 1;
      wait_drained();
      repeat (400) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
